/* hw/rtl/tmlp_pkg.sv */
// Shared types and constants for the tiny MLP inference block.
package tmlp_pkg;

  localparam int HIDDEN_UNITS_DEF = 4;
  localparam int OUTPUT_UNITS_DEF = 11;
  localparam int FRAC_BITS_DEF    = 12;

  localparam int PARAM_W = 16;  // stored parameter, signed Q3.F
  localparam int PROD_W  = 32;  // one product or shifted bias
  localparam int ACC_W   = 36;  // pre-activation accumulator
  localparam int ACT_W   = 16;  // signed activation in Q.14

  // Activation table: act(k/16) for k = 0..128 in Q.14, negative side by symmetry
  localparam int TBL_FRAC  = 14;
  localparam int TBL_DEPTH = 129;
  localparam int TBL_AW    = 8;
  localparam int TBL_DW    = 15;

  localparam int              EXP_W        = 30;
  localparam logic [EXP_W-1:0] EXP_STEP_Q30 = 30'd1008687096;  // e^-1/16 in Q30

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_INFER = 1'b1
  } req_t;

  typedef struct packed {
    logic                en;
    logic [TBL_AW-1:0]   addr;
    logic [TBL_DW-1:0]   data;
  } tbl_wr_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic bias;
  } mac_ctrl_t;

endpackage

/* hw/rtl/tmlp_act_init.sv */
// Builds the activation table after reset with a shift-subtract divider.
module tmlp_act_init import tmlp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  output tbl_wr_t tbl_wr,
  output logic    init_done
);

  localparam int E_W   = 31;
  localparam int DEN_W = 32;
  localparam int NUM_W = 45;
  localparam int STEP_W = $clog2(TBL_DW);

  typedef enum logic [1:0] {
    I_LOAD,
    I_DIV,
    I_FIN,
    I_DONE
  } init_state_t;

  init_state_t         state_r;
  logic [E_W-1:0]      e_r;
  logic [TBL_AW-1:0]   k_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic [TBL_DW-1:0]   low_r;
  logic [TBL_DW-1:0]   quo_r;
  logic [STEP_W-1:0]   step_r;
  tbl_wr_t             wr_r;
  logic                done_r;

  logic [E_W-1:0]      num;
  logic [DEN_W-1:0]    den;
  logic [NUM_W-1:0]    dividend;
  logic [E_W+EXP_W-1:0] eprod;
  logic [E_W-1:0]      e_nxt;
  logic [DEN_W:0]      trial;
  logic                qbit;
  logic [DEN_W-1:0]    rem_nxt;

  always_comb begin
    num      = E_W'(32'd1 << 30) - e_r;
    den      = DEN_W'(32'd1 << 30) + DEN_W'(e_r);
    dividend = (NUM_W'(num) << TBL_FRAC) + NUM_W'(den >> 1);
    eprod    = e_r * EXP_STEP_Q30;
    e_nxt    = E_W'((eprod + (E_W+EXP_W)'(32'd1 << 29)) >> 30);
    trial    = {rem_r, low_r[TBL_DW-1]};
    qbit     = (trial >= {1'b0, den_r});
    rem_nxt  = qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= I_LOAD;
      e_r     <= E_W'(32'd1 << 30);
      k_r     <= '0;
      step_r  <= '0;
      wr_r    <= '0;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        I_LOAD: begin
          // quotient stays below 2^15, so the top bits start as the remainder
          wr_r.en <= 1'b0;
          rem_r   <= DEN_W'(dividend[NUM_W-1:TBL_DW]);
          low_r   <= dividend[TBL_DW-1:0];
          den_r   <= den;
          e_r     <= e_nxt;
          step_r  <= '0;
          state_r <= I_DIV;
        end
        I_DIV: begin
          rem_r   <= rem_nxt;
          low_r   <= {low_r[TBL_DW-2:0], 1'b0};
          quo_r   <= {quo_r[TBL_DW-2:0], qbit};
          step_r  <= step_r + 1'b1;
          wr_r.en <= (step_r == STEP_W'(TBL_DW - 1));
          if (step_r == STEP_W'(TBL_DW - 1)) begin
            wr_r.addr <= k_r;
            wr_r.data <= {quo_r[TBL_DW-2:0], qbit};
            if (k_r == TBL_AW'(TBL_DEPTH - 1)) begin
              state_r <= I_FIN;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= I_LOAD;
            end
          end
        end
        I_FIN: begin
          wr_r.en <= 1'b0;
          done_r  <= 1'b1;
          state_r <= I_DONE;
        end
        I_DONE: begin
          wr_r.en <= 1'b0;
          done_r  <= 1'b1;
        end
        default: begin
          wr_r.en <= 1'b0;
          state_r <= I_LOAD;
        end
      endcase
    end
  end

  assign tbl_wr    = wr_r;
  assign init_done = done_r;

endmodule

/* hw/rtl/tmlp_mac_unit.sv */
// Shared multiply-accumulate unit: one product per cycle into a 36-bit accumulator.
module tmlp_mac_unit import tmlp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic signed [PARAM_W-1:0] coef,
  input  logic signed [PARAM_W-1:0] opnd,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     done
);

  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] bias_ext;
  logic signed [PROD_W-1:0] prod_r;
  mac_ctrl_t                s2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;

  assign mult     = opnd * coef;
  assign bias_ext = PROD_W'(coef) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    prod_r <= ctrl.bias ? bias_ext : mult;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r   <= '0;
      acc_r  <= '0;
      done_r <= 1'b0;
    end else begin
      s2_r   <= ctrl;
      done_r <= s2_r.vld & s2_r.last;
      if (s2_r.vld) begin
        acc_r <= s2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

/* hw/rtl/tiny_mlp_inference_top.sv */
// Top level of the tiny MLP inference block: sequencer, parameter store and activation table.
//
// After reset the block first builds its 129-entry activation table through a
// shift-subtract divider, one entry at a time; in_tready stays low until then. A write
// beat (tuser 0) stores one parameter. An infer beat (tuser 1) runs through the shared
// multiply-accumulator, which takes one parameter product per cycle, followed by a table
// lookup for each unit, first for the hidden layer and then for each output. Results
// leave through an output register; a stalled consumer holds the sequencer only when a
// new result is due.
module tiny_mlp_inference_top import tmlp_pkg::*; #(
  parameter int HIDDEN_UNITS = HIDDEN_UNITS_DEF,
  parameter int OUTPUT_UNITS = OUTPUT_UNITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_index, entry_value, stimulus, zero pad
  input  logic                   in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_index, out_value, zero pad
  output logic                   out_tlast
);

  localparam int PARAM_COUNT = 2 * HIDDEN_UNITS + HIDDEN_UNITS * OUTPUT_UNITS + OUTPUT_UNITS;
  localparam int PADDR_W     = $clog2(PARAM_COUNT);
  localparam int OW_BASE     = 2 * HIDDEN_UNITS;
  localparam int OB_BASE     = 2 * HIDDEN_UNITS + HIDDEN_UNITS * OUTPUT_UNITS;
  localparam int HID_W       = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int MAX_UNITS   = (HIDDEN_UNITS > OUTPUT_UNITS) ? HIDDEN_UNITS : OUTPUT_UNITS;
  localparam int UNIT_W      = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int K_W         = $clog2(HIDDEN_UNITS + 1);
  localparam int ZSHIFT      = 2 * FRAC_BITS - 4;
  localparam int HSHIFT      = TBL_FRAC - FRAC_BITS;
  localparam int IDX_W       = 4;
  localparam int VAL_W       = 15;
  localparam int M50_W       = ACT_W + 6;

  localparam logic signed [ACC_W-1:0] ZMIN = ACC_W'(-128);
  localparam logic signed [ACC_W-1:0] ZMAX = ACC_W'(127);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_LOOK
  } seq_state_t;

  // input fields
  logic [5:0]                 in_entry_index;
  logic signed [PARAM_W-1:0]  in_entry_value;
  logic signed [PARAM_W-1:0]  in_stimulus;
  logic                       in_acc;

  // sequencer
  seq_state_t                 state_r;
  logic                       out_phase_r;
  logic [UNIT_W-1:0]          unit_r;
  logic [K_W-1:0]             k_r;
  logic [K_W-1:0]             k_max;
  logic signed [PARAM_W-1:0]  x_r;
  logic signed [PARAM_W-1:0]  hidden_r [HIDDEN_UNITS];
  mac_ctrl_t                  iss_ctrl_r;
  logic signed [PARAM_W-1:0]  iss_opnd_r;

  // parameter store
  logic signed [PARAM_W-1:0]  prm_mem [PARAM_COUNT];
  logic [PADDR_W-1:0]         prm_raddr;
  logic signed [PARAM_W-1:0]  prm_rd_r;
  logic                       prm_we;

  // activation table
  tbl_wr_t                    tbl_wr;
  logic                       init_done;
  logic [TBL_DW-1:0]          tbl_mem [TBL_DEPTH];
  logic [TBL_DW-1:0]          tbl_rd_r;
  logic                       tbl_neg_r;
  logic [TBL_AW-1:0]          tbl_raddr;
  logic                       tbl_neg;

  // arithmetic
  logic signed [ACC_W-1:0]    acc;
  logic                       mac_done;
  logic signed [ACC_W-1:0]    zq;
  logic signed [7:0]          q_sat;
  logic signed [ACT_W-1:0]    act;
  logic signed [PARAM_W-1:0]  hid_new;
  logic signed [M50_W-1:0]    act_ext;
  logic signed [M50_W-1:0]    m50;
  logic signed [M50_W-1:0]    m50_sh;

  // output register
  logic                       out_load;
  logic                       out_tvalid_r;
  logic [IDX_W-1:0]           out_index_r;
  logic [VAL_W-1:0]           out_value_r;
  logic                       out_tlast_r;

  assign in_entry_index = in_tdata[5:0];
  assign in_entry_value = in_tdata[21:6];
  assign in_stimulus    = in_tdata[37:22];

  assign in_tready = (state_r == S_IDLE) && init_done;
  assign in_acc    = in_tvalid && in_tready;
  assign prm_we    = in_acc && (in_tuser == REQ_WRITE) && (32'(in_entry_index) < PARAM_COUNT);

  tmlp_act_init u_act_init (
    .clk       (clk),
    .rst_n     (rst_n),
    .tbl_wr    (tbl_wr),
    .init_done (init_done)
  );

  tmlp_mac_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (iss_ctrl_r),
    .coef  (prm_rd_r),
    .opnd  (iss_opnd_r),
    .acc   (acc),
    .done  (mac_done)
  );

  // Parameter address: bias first, then weights
  always_comb begin
    if (!out_phase_r) begin
      prm_raddr = (k_r == '0) ? PADDR_W'(HIDDEN_UNITS) + PADDR_W'(unit_r)
                              : PADDR_W'(unit_r);
    end else if (k_r == '0) begin
      prm_raddr = PADDR_W'(OB_BASE) + PADDR_W'(unit_r);
    end else begin
      prm_raddr = PADDR_W'(OW_BASE) + PADDR_W'(k_r - 1'b1) * PADDR_W'(OUTPUT_UNITS)
                + PADDR_W'(unit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (prm_we) begin
      prm_mem[PADDR_W'(in_entry_index)] <= in_entry_value;
    end
    prm_rd_r <= prm_mem[prm_raddr];
  end

  // Saturate the pre-activation to table steps of 1/16 and fold by symmetry
  always_comb begin
    zq = acc >>> ZSHIFT;
    if (zq < ZMIN) begin
      q_sat = 8'sh80;
    end else if (zq > ZMAX) begin
      q_sat = 8'sh7f;
    end else begin
      q_sat = zq[7:0];
    end
    tbl_neg   = q_sat[7];
    tbl_raddr = tbl_neg ? TBL_AW'(-q_sat) : TBL_AW'(q_sat);
  end

  always_ff @(posedge clk) begin
    if (tbl_wr.en) begin
      tbl_mem[tbl_wr.addr] <= tbl_wr.data;
    end
    tbl_rd_r  <= tbl_mem[tbl_raddr];
    tbl_neg_r <= tbl_neg;
  end

  always_comb begin
    act     = tbl_neg_r ? -$signed({1'b0, tbl_rd_r}) : $signed({1'b0, tbl_rd_r});
    hid_new = act >>> HSHIFT;
    act_ext = {{(M50_W-ACT_W){act[ACT_W-1]}}, act};
    m50     = (act_ext <<< 5) + (act_ext <<< 4) + (act_ext <<< 1);
    m50_sh  = m50 >>> 6;
  end

  assign k_max    = out_phase_r ? K_W'(HIDDEN_UNITS) : K_W'(1);
  assign out_load = (state_r == S_LOOK) && out_phase_r && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_phase_r  <= 1'b0;
      unit_r       <= '0;
      k_r          <= '0;
      iss_ctrl_r   <= '0;
      out_tvalid_r <= 1'b0;
      out_tlast_r  <= 1'b0;
      for (int j = 0; j < HIDDEN_UNITS; j++) begin
        hidden_r[j] <= '0;
      end
    end else begin
      if (state_r != S_ISSUE) begin
        iss_ctrl_r.vld <= 1'b0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == REQ_INFER)) begin
            x_r         <= in_stimulus;
            out_phase_r <= 1'b0;
            unit_r      <= '0;
            k_r         <= '0;
            state_r     <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          iss_ctrl_r <= '{vld: 1'b1, first: (k_r == '0), last: (k_r == k_max),
                          bias: (k_r == '0)};
          iss_opnd_r <= out_phase_r ? hidden_r[HID_W'(k_r - 1'b1)] : x_r;
          if (k_r == k_max) begin
            k_r     <= '0;
            state_r <= S_WAIT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_WAIT: begin
          // table address follows the final accumulator this cycle
          if (mac_done) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!out_phase_r) begin
            hidden_r[HID_W'(unit_r)] <= hid_new;
            state_r                  <= S_ISSUE;
            if (unit_r == UNIT_W'(HIDDEN_UNITS - 1)) begin
              out_phase_r <= 1'b1;
              unit_r      <= '0;
            end else begin
              unit_r <= unit_r + 1'b1;
            end
          end else if (out_load) begin
            out_index_r  <= IDX_W'(unit_r);
            out_value_r  <= m50_sh[VAL_W-1:0];
            out_tlast_r  <= (unit_r == UNIT_W'(OUTPUT_UNITS - 1));
            if (unit_r == UNIT_W'(OUTPUT_UNITS - 1)) begin
              unit_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              unit_r  <= unit_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-IDX_W-VAL_W){1'b0}}, out_value_r, out_index_r};
  assign out_tlast  = out_tlast_r;

  a_mac_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_WAIT)
    else $error("accumulator finished outside the wait state");

  a_no_work_before_table: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> (state_r == S_IDLE) && !out_tvalid_r)
    else $error("inference activity before the activation table is built");

  a_table_write_only_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> !init_done)
    else $error("activation table written after initialization");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (unit_r == UNIT_W'(OUTPUT_UNITS - 1))) |=>
      (state_r == S_IDLE) && out_tlast_r && out_tvalid_r)
    else $error("final result did not end the inference");

endmodule

/* bench/tmlp_output_checker.sv */
// Result checker for the tiny MLP block: tracks parameter writes, predicts each inference.
`timescale 1ns / 100ps

module tmlp_output_checker import tmlp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_index, entry_value, stimulus, zero pad
  input  logic                   in_tuser,   // req_type
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // out_index, out_value, zero pad
  input  logic                   out_tlast,
  input  logic                   end_check,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  localparam int H           = HIDDEN_UNITS_DEF;
  localparam int O           = OUTPUT_UNITS_DEF;
  localparam int F           = FRAC_BITS_DEF;
  localparam int OW_BASE     = 2 * H;
  localparam int OB_BASE     = 2 * H + H * O;
  localparam int PARAM_COUNT = 2 * H + H * O + O;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [14:0] value;
    logic               is_last;
  } mlp_result_t;

  int          act_lut [256];
  int          net_params [PARAM_COUNT];
  mlp_result_t expected_outputs [$];
  bit          end_done;

  // act(k/16) in Q.14 for k = -128..127, odd symmetric
  initial begin : build_lut
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    int              pos [129];
    e = 64'd1 << 30;
    for (int k = 0; k <= 128; k++) begin
      num    = (64'd1 << 30) - e;
      den    = (64'd1 << 30) + e;
      pos[k] = int'(((num << TBL_FRAC) + den / 2) / den);
      e      = (e * longint'(EXP_STEP_Q30) + (64'd1 << 29)) >> 30;
    end
    for (int k = -128; k < 128; k++) begin
      act_lut[k + 128] = (k >= 0) ? pos[k] : -pos[-k];
    end
  end

  // z carries 2F fraction bits; saturate the index to the table span
  function automatic int sigmoid_q14(input longint z);
    longint q;
    q = z >>> (2 * F - 4);
    if (q < -128) q = -128;
    if (q > 127) q = 127;
    return act_lut[q + 128];
  endfunction

  task automatic predict_inference(input logic signed [15:0] x);
    int          hid [H];
    longint      acc;
    int          v;
    mlp_result_t r;
    for (int j = 0; j < H; j++) begin
      acc    = longint'(x) * net_params[j] + (longint'(net_params[H + j]) <<< F);
      hid[j] = sigmoid_q14(acc) >>> (TBL_FRAC - F);
    end
    for (int i = 0; i < O; i++) begin
      acc = longint'(net_params[OB_BASE + i]) <<< F;
      for (int j = 0; j < H; j++) begin
        acc += longint'(hid[j]) * net_params[OW_BASE + j * O + i];
      end
      v         = (sigmoid_q14(acc) * 50) >>> 6;
      r.index   = 4'(i);
      r.value   = 15'(v);
      r.is_last = (i == O - 1);
      expected_outputs.push_back(r);
    end
  endtask

  always @(posedge clk) begin : monitor
    mlp_result_t got;
    mlp_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_WRITE) begin
          // slots past the layout are dropped by the block
          if (in_tdata[5:0] < PARAM_COUNT) begin
            net_params[in_tdata[5:0]] = int'($signed(in_tdata[21:6]));
          end
        end else begin
          predict_inference($signed(in_tdata[37:22]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.index   = out_tdata[3:0];
        got.value   = out_tdata[18:4];
        got.is_last = out_tlast;
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got index %0d value %0d last %0b",
                   $time, got.index, $signed(got.value), got.is_last);
          fail_count++;
        end else begin
          want = expected_outputs.pop_front();
          checked++;
          if (got.index !== want.index) begin
            $display("%0t: out_index mismatch: expected %0d, got %0d",
                     $time, want.index, got.index);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $display("%0t: out_value mismatch at output %0d: expected %0d, got %0d",
                     $time, want.index, $signed(want.value), $signed(got.value));
            fail_count++;
          end
          if (got.is_last !== want.is_last) begin
            $display("%0t: out_tlast mismatch at output %0d: expected %0b, got %0b",
                     $time, want.index, want.is_last, got.is_last);
            fail_count++;
          end
        end
      end
      if (end_check && !end_done) begin
        if (expected_outputs.size() != 0) begin
          $display("%0t: results never arrived: expected %0d more, got 0",
                   $time, expected_outputs.size());
          fail_count += expected_outputs.size();
        end
        end_done = 1'b1;
      end
    end
    pending <= expected_outputs.size();
  end

endmodule

/* bench/tb_tiny_mlp_inference_top.sv */
// Stimulus and verdict for the tiny MLP inference block.
`timescale 1ns / 100ps

module tb_tiny_mlp_inference_top;
  import tmlp_pkg::*;

  localparam int PARAM_SLOTS    = 2 * HIDDEN_UNITS_DEF + HIDDEN_UNITS_DEF * OUTPUT_UNITS_DEF
                                  + OUTPUT_UNITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 70;
  localparam int DRAIN_CYCLES   = 150;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // entry_index, entry_value, stimulus, zero pad
  logic                   in_tuser = 1'b0; // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_index, out_value, zero pad
  logic                   out_tlast;
  logic                   end_check = 1'b0;

  int fail_count;
  int pending;
  int checked;
  bit idle_on;
  int hold_seq;
  int n_writes;
  int n_infers;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tiny_mlp_inference_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  tmlp_output_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .end_check (end_check),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen  = hold_seq;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_tiny_mlp_inference_top: errors");
    $finish;
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // mostly moderate values, a quarter over the full Q3.12 range
  function automatic logic [15:0] param_value();
    if ($urandom_range(0, 3) == 0) return rand16();
    return 16'(int'($urandom_range(0, 12000)) - 6000);
  endfunction

  // Hold valid until the beat is taken; valid stays high into the next beat
  task automatic send_beat(input req_t req, input logic [5:0] idx,
                           input logic [15:0] value, input logic [15:0] stim);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, stim, value, idx};
    do @(posedge clk); while (!in_tready);
    if (req == REQ_WRITE) n_writes++;
    else n_infers++;
  endtask

  task automatic write_param(input logic [5:0] idx, input logic [15:0] value);
    send_beat(REQ_WRITE, idx, value, rand16());
  endtask

  task automatic infer(input logic [15:0] x);
    send_beat(REQ_INFER, 6'($urandom_range(0, 63)), rand16(), x);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // fill every slot so no inference reads an unwritten parameter
    for (int s = 0; s < PARAM_SLOTS; s++) begin
      write_param(6'(s), param_value());
    end

    infer(16'h0000);
    infer(16'h7FFF);
    infer(16'h8000);
    infer(16'h0001);
    infer(16'hFFFF);
    write_param(6'd63, 16'h7FFF);  // past the layout, dropped
    write_param(6'd0, 16'h7FFF);
    write_param(6'd4, 16'h7FFF);
    infer(16'h7FFF);
    write_param(6'd0, 16'h8000);
    write_param(6'd4, 16'h8000);
    infer(16'h7FFF);
    write_param(6'd52, 16'h8000);
    write_param(6'd62, 16'h7FFF);
    write_param(6'd8, 16'h7FFF);
    infer(16'h8000);
    write_param(6'd0, 16'h0000);
    write_param(6'd4, 16'h0000);
    infer(16'h1234);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n < RANDOM_ITEMS - 20) && ((n % 25) < 20);
      if (n == 20) hold_seq++;
      if (n == 40) drain_results();
      // back-to-back inferences while the sink holds off fill the block
      if ((n >= 20 && n < 28) || $urandom_range(0, 9) < 4) begin
        infer(rand16());
      end else begin
        write_param(6'($urandom_range(0, 63)), param_value());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Summary: %0d parameter writes and %0d inferences sent, %0d result beats compared.",
             n_writes, n_infers, checked);
    $display("Summary: field extremes, saturated activations, a dropped slot write,");
    $display("         a long sink stall and a mid-run drain.");
    if (fail_count == 0) begin
      $display("tb_tiny_mlp_inference_top: clean");
    end else begin
      $display("tb_tiny_mlp_inference_top: errors");
    end
    $finish;
  end

endmodule
